// File: rtl/rssc_pkg.sv
// ----------------------------------------------------------------------------
// rssc_pkg: shared types, constants and helpers
// Item layouts, queue entry layout, command and mode codes and the
// modulo-26 adder used by the front and back parts of the rotor cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package rssc_pkg;

  localparam int unsigned LETTERS     = 26;
  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned ROTORS      = 3;
  localparam int unsigned SEL_W       = 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0]   CHAR_A       = 8'd65;
  localparam logic [CHAR_W-1:0]   CHAR_Z       = 8'd90;
  localparam logic [LETTER_W-1:0] OFFSET_RESET = 5'd4;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CHAR = 1'b1;

  // Mode codes.
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'b1;

  typedef struct packed {
    logic                command;
    logic [SEL_W-1:0]    rotor_select;
    logic [LETTER_W-1:0] entry_index;
    logic [LETTER_W-1:0] entry_letter;
    logic [CHAR_W-1:0]   char_in;
    logic                first_of_message;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              passed_through;
  } out_item_t;

  // One classified operation as it travels from the front to the back.
  typedef struct packed {
    logic                is_load;      // rotor entry write, no result
    logic                load_ok;      // load fields in range
    logic [SEL_W-1:0]    sel;
    logic [LETTER_W-1:0] eidx;
    logic [LETTER_W-1:0] elet;
    logic                letter;       // uppercase letter to be ciphered
    logic                mode;
    logic [CHAR_W-1:0]   ch;
    logic [LETTER_W-1:0] val;          // shifted index (encode) or raw index
    logic [LETTER_W-1:0] shift;
  } rssc_op_t;

  // Sum of two letter indexes, both below LETTERS, taken modulo LETTERS.
  function automatic logic [LETTER_W-1:0] mod_add(input logic [LETTER_W-1:0] a,
                                                  input logic [LETTER_W-1:0] b);
    logic [LETTER_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (LETTER_W+1)'(LETTERS)) begin
      sum = sum - (LETTER_W+1)'(LETTERS);
    end
    return sum[LETTER_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/rssc_front.sv
// ----------------------------------------------------------------------------
// rssc_front: input acceptance and classification
// Tracks the message position, works out the shift and turns every item
// into a queue entry for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module rssc_front import rssc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire in_item_t            in_data,
  input  wire logic                mode,
  input  wire logic [LETTER_W-1:0] start_offset,
  output      logic                push_valid,
  input  wire logic                push_ready,
  output      rssc_op_t            push_data
);

  logic [LETTER_W-1:0] pos_r, pos_nxt;
  logic [LETTER_W-1:0] pos_cur;
  logic [LETTER_W-1:0] off_m;
  logic [LETTER_W-1:0] shift;
  logic [CHAR_W-1:0]   rel;
  logic                accept;
  logic                is_char;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;
  assign is_char    = (in_data.command == CMD_CHAR);

  always_comb begin
    pos_cur = in_data.first_of_message ? '0 : pos_r;
    off_m   = (start_offset >= LETTER_W'(LETTERS)) ?
              start_offset - LETTER_W'(LETTERS) : start_offset;
    shift   = mod_add(pos_cur, off_m);
    rel     = in_data.char_in - CHAR_A;

    push_data.is_load = ~is_char;
    push_data.load_ok = (in_data.rotor_select < SEL_W'(ROTORS)) &&
                        (in_data.entry_index < LETTER_W'(LETTERS)) &&
                        (in_data.entry_letter < LETTER_W'(LETTERS));
    push_data.sel     = in_data.rotor_select;
    push_data.eidx    = in_data.entry_index;
    push_data.elet    = in_data.entry_letter;
    push_data.letter  = (in_data.char_in >= CHAR_A) && (in_data.char_in <= CHAR_Z);
    push_data.mode    = mode;
    push_data.ch      = in_data.char_in;
    push_data.shift   = shift;
    push_data.val     = (mode == MODE_ENC) ? mod_add(rel[LETTER_W-1:0], shift)
                                           : rel[LETTER_W-1:0];

    pos_nxt = pos_r;
    if (accept && is_char) begin
      pos_nxt = mod_add(pos_cur, LETTER_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rssc_queue.sv
// ----------------------------------------------------------------------------
// rssc_queue: short operation queue
// Two-entry first-in first-out buffer between the front and back parts;
// a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rssc_queue import rssc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output      logic     push_ready,
  input  wire rssc_op_t push_data,
  output      logic     pop_valid,
  input  wire logic     pop_ready,
  output      rssc_op_t pop_data
);

  rssc_op_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                     push, pop;

  assign push_ready = (cnt_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                              : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                              : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rssc_back.sv
// ----------------------------------------------------------------------------
// rssc_back: rotor tables and cipher datapath
// Applies rotor loads, runs letters through the three rotors and holds the
// result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rssc_back import rssc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     pop_valid,
  output      logic     pop_ready,
  input  wire rssc_op_t pop_data,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output      out_item_t out_data
);

  typedef logic [LETTER_W-1:0] rotor_t [LETTERS];

  rotor_t              fwd_r [ROTORS];
  rotor_t              inv_r [ROTORS];
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic                fire;
  logic [LETTER_W-1:0] v1, v2, v3, back_shift, res_idx;
  logic [CHAR_W-1:0]   res_char;

  // Entries beyond the alphabet read as letter A.
  function automatic logic [LETTER_W-1:0] rd(input rotor_t tbl,
                                             input logic [LETTER_W-1:0] idx);
    logic [LETTER_W-1:0] v;
    v = '0;
    if (idx < LETTER_W'(LETTERS)) begin
      v = tbl[idx];
    end
    return v;
  endfunction

  assign pop_ready = ~out_valid_r | out_ready;
  assign fire      = pop_valid & pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (pop_data.mode == MODE_ENC) begin
      v1 = rd(fwd_r[0], pop_data.val);
      v2 = rd(fwd_r[1], v1);
      v3 = rd(fwd_r[2], v2);
      back_shift = '0;
      res_idx    = v3;
    end else begin
      v1 = rd(inv_r[2], pop_data.val);
      v2 = rd(inv_r[1], v1);
      v3 = rd(inv_r[0], v2);
      back_shift = (pop_data.shift == '0) ? '0 : LETTER_W'(LETTERS) - pop_data.shift;
      res_idx    = mod_add(v3, back_shift);
    end
    res_char = CHAR_A + CHAR_W'(res_idx);

    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    if (fire && !pop_data.is_load) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.char_out       = pop_data.letter ? res_char : pop_data.ch;
      out_data_nxt.passed_through = ~pop_data.letter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (fire && pop_data.is_load && pop_data.load_ok) begin
      fwd_r[pop_data.sel[SEL_W-1:0]][pop_data.eidx] <= pop_data.elet;
      inv_r[pop_data.sel[SEL_W-1:0]][pop_data.elet] <= pop_data.eidx;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rotor_shift_substitution_cipher_top.sv
// ----------------------------------------------------------------------------
// rotor_shift_substitution_cipher_top: three-rotor cipher with a shift
// Enciphers or deciphers uppercase ASCII letters one item at a time and
// passes every other byte through; rotor entries are loaded as items.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------
//   in_      | input     | in_valid / in_ready  | in_data   (in_item_t)
//   out_     | output    | out_valid / out_ready| out_data  (out_item_t)
//   cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item can be accepted in every cycle while the queue has room. A character
// item passes the queue register and then the output register before it shows
// up on the output. Loads give no output item.
// Reset clears the position counter, the queue and the output valid flag and
// sets mode to encode and the offset to four; rotor tables hold nothing
// meaningful until loaded. A stalled output fills the two-entry queue, after
// which in_ready drops until the output is taken again.
// ----------------------------------------------------------------------------
`default_nettype none

module rotor_shift_substitution_cipher_top import rssc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire in_item_t              in_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      out_item_t             out_data,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers. Writes are taken at any time; the user only
  // writes while the block is idle, so no item sees a change midway.
  logic                mode_r, mode_nxt;
  logic [LETTER_W-1:0] offset_r, offset_nxt;

  rssc_op_t push_data, pop_data;
  logic     push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt   = mode_r;
    offset_nxt = offset_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:   mode_nxt   = cfg_data[0];
        CFG_OFFSET: offset_nxt = cfg_data[LETTER_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ENC;
      offset_r <= OFFSET_RESET;
    end else begin
      mode_r   <= mode_nxt;
      offset_r <= offset_nxt;
    end
  end

  // The front classifies each item and computes the shift from the position.
  rssc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .mode         (mode_r),
    .start_offset (offset_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  // The queue lets the front keep accepting while the back waits on out_ready.
  rssc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back owns the rotor tables; loads and characters reach it in order.
  rssc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the three-rotor shift substitution cipher
// Loads rotor permutations, streams characters in both modes and under
// several offsets, predicts every output character and checks each result
// item in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb;
  import rssc_pkg::*;

  localparam int IN_W           = $bits(in_item_t);
  // Loads leave nothing on the output, so after the last result the block
  // may still hold a load; this covers queue plus output register with
  // room to spare.
  localparam int SETTLE_CYCLES  = 4;
  // The longest legal stretch without any handshake is a sender gap plus a
  // receiver stall; this is far beyond either.
  localparam int WATCHDOG_LIMIT = 2000;

  // Receiver stall styles. Each holds for a random stretch.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our own copy of the cipher state, updated as items are accepted.
  logic [LETTER_W-1:0] fwd_rotor [ROTORS][LETTERS];
  logic [LETTER_W-1:0] inv_rotor [ROTORS][LETTERS];
  int                  pos_count = 0;
  logic                cur_mode = MODE_ENC;
  logic [CFG_DATA_W-1:0] cur_offset = OFFSET_RESET;

  // Output characters predicted for accepted character items, oldest first.
  out_item_t expected_cipher [$];

  int        fail_count = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  rx_style_t rx_style = RX_STREAM;
  int        rx_left = 0;

  rotor_shift_substitution_cipher_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out the effect of one accepted item. A load updates the rotor
  // copies and yields nothing; a character item yields one output item,
  // which is queued for the checker.
  task automatic cipher_predict(input in_item_t it);
    int        shift;
    int        v;
    out_item_t res;
    if (it.command == CMD_LOAD) begin
      // Out-of-range selects or letters make the whole load a no-op.
      if (int'(it.rotor_select) < int'(ROTORS) && int'(it.entry_index) < int'(LETTERS) &&
          int'(it.entry_letter) < int'(LETTERS)) begin
        fwd_rotor[it.rotor_select][it.entry_index] = it.entry_letter;
        inv_rotor[it.rotor_select][it.entry_letter] = it.entry_index;
      end
    end else begin
      if (it.first_of_message) begin
        pos_count = 0;
      end
      res.char_out       = it.char_in;
      res.passed_through = 1'b1;
      if (it.char_in >= CHAR_A && it.char_in <= CHAR_Z) begin
        // Offsets above 25 wrap before they are added to the position.
        shift = (pos_count + int'(cur_offset) % int'(LETTERS)) % int'(LETTERS);
        v     = int'(it.char_in) - int'(CHAR_A);
        if (cur_mode == MODE_ENC) begin
          v = (v + shift) % int'(LETTERS);
          v = int'(fwd_rotor[0][v]);
          v = int'(fwd_rotor[1][v]);
          v = int'(fwd_rotor[2][v]);
        end else begin
          v = int'(inv_rotor[2][v]);
          v = int'(inv_rotor[1][v]);
          v = int'(inv_rotor[0][v]);
          v = (v + int'(LETTERS) - shift) % int'(LETTERS);
        end
        res.char_out       = CHAR_W'(int'(CHAR_A) + v);
        res.passed_through = 1'b0;
      end
      // Every character, letter or not, moves the position on.
      pos_count = (pos_count + 1) % int'(LETTERS);
      expected_cipher.push_back(res);
    end
  endtask

  // Character item; the load fields are filled with noise since the block
  // must ignore them.
  function automatic in_item_t make_char(input logic [CHAR_W-1:0] ch, input logic first);
    in_item_t it;
    it                  = in_item_t'(IN_W'($urandom));
    it.command          = CMD_CHAR;
    it.char_in          = ch;
    it.first_of_message = first;
    return it;
  endfunction

  // Load item; char_in and first_of_message are noise here.
  function automatic in_item_t make_load(input int sel, input int idx, input int ltr);
    in_item_t it;
    it              = in_item_t'(IN_W'($urandom));
    it.command      = CMD_LOAD;
    it.rotor_select = SEL_W'(sel);
    it.entry_index  = LETTER_W'(idx);
    it.entry_letter = LETTER_W'(ltr);
    return it;
  endfunction

  // Offer one item and return once it is accepted. The sender runs in
  // bursts; at the end of each burst valid drops for a random gap. Valid is
  // left high on return so back-to-back items need no extra assignment.
  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cipher_predict(it);
  endtask

  // Stop sending and wait until every predicted result has come out, then
  // give any trailing load time to retire.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_cipher.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back. Only called with the block idle.
  // The upper bits of the mode write carry noise, which the block drops.
  task automatic program_regs(input logic m, input logic [CFG_DATA_W-1:0] off);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= CFG_DATA_W'({$urandom, m});
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_mode = m;
    cfg_index <= CFG_OFFSET;
    cfg_data  <= off;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_offset = off;
    cfg_valid <= 1'b0;
  endtask

  // Fill all three rotors with fresh random permutations, which also
  // writes every inverse entry.
  task automatic load_all_rotors();
    int perm [LETTERS];
    int j;
    int tmp;
    for (int sel = 0; sel < int'(ROTORS); sel++) begin
      for (int i = 0; i < int'(LETTERS); i++) begin
        perm[i] = i;
      end
      for (int i = int'(LETTERS) - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        tmp     = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      for (int i = 0; i < int'(LETTERS); i++) begin
        send_item(make_load(sel, i, perm[i]));
      end
    end
  endtask

  // Non-letters pass through untouched, even before any rotor is loaded.
  // The bytes right next to the uppercase range and both byte extremes
  // are the interesting ones.
  task automatic test_passthrough();
    send_item(make_char(8'h00, 1'b1));
    send_item(make_char(8'hff, 1'b0));
    send_item(make_char(CHAR_A - 8'd1, 1'b0));
    send_item(make_char(CHAR_Z + 8'd1, 1'b0));
    send_item(make_char(8'h61, 1'b1));
    send_item(make_char(8'h7a, 1'b0));
  endtask

  // Encode with the reset configuration. A load in the middle of a message
  // must not touch the position, whatever its ignored fields say; it
  // rewrites an entry with the letter it already holds.
  task automatic test_encode_reset_config();
    int idx;
    idx = $urandom_range(0, 25);
    send_item(make_char(CHAR_A, 1'b1));
    send_item(make_char(CHAR_Z, 1'b0));
    send_item(make_char(CHAR_A - 8'd1, 1'b0));
    send_item(make_load(0, idx, int'(fwd_rotor[0][idx])));
    send_item(make_char(CHAR_A + 8'd1, 1'b0));
  endtask

  // Loads with a rotor select of three or a letter index above 25 are
  // dropped entirely; the characters after them show the rotors unchanged.
  task automatic test_bad_loads();
    send_item(make_load(3, 0, 5));
    send_item(make_load(0, 26, 0));
    send_item(make_load(0, 0, 31));
    send_item(make_load(2, 31, 31));
    send_item(make_char(CHAR_A, 1'b1));
    send_item(make_char(CHAR_A + 8'd5, 1'b0));
  endtask

  // Decode, and offsets at both ends of the register range, including
  // values above 25 that must wrap.
  task automatic test_offsets_and_decode();
    drain_results();
    program_regs(MODE_DEC, 5'd31);
    send_item(make_char(CHAR_A, 1'b1));
    send_item(make_char(CHAR_Z, 1'b0));
    drain_results();
    program_regs(MODE_DEC, 5'd0);
    send_item(make_char(CHAR_A, 1'b1));
    send_item(make_char(CHAR_A + 8'd13, 1'b0));
    drain_results();
    program_regs(MODE_ENC, 5'd25);
    send_item(make_char(CHAR_Z, 1'b1));
    send_item(make_char(CHAR_A, 1'b0));
  endtask

  // Two entries of one rotor mapping to the same letter: the inverse entry
  // keeps the index of the latest load of that letter.
  task automatic test_non_permutation();
    drain_results();
    program_regs(MODE_DEC, 5'd26);
    send_item(make_load(1, 5, int'(fwd_rotor[1][6])));
    send_item(make_char(CHAR_A, 1'b1));
    send_item(make_char(CHAR_A + 8'd12, 1'b0));
    send_item(make_char(CHAR_Z, 1'b0));
  endtask

  // Long random run in several phases. Most items are characters grouped
  // into messages, mostly letters; a few are loads, some of them out of
  // range. Some phases start from freshly loaded rotors.
  task automatic test_random_traffic();
    in_item_t          it;
    logic [CHAR_W-1:0] ch;
    logic              first;
    int                roll;
    int                msg_left;
    logic              m;
    logic [CFG_DATA_W-1:0] off;
    msg_left = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          m   = MODE_ENC;
          off = 5'd0;
        end
        1: begin
          m   = MODE_DEC;
          off = 5'd25;
        end
        2: begin
          m   = MODE_ENC;
          off = 5'd31;
        end
        3: begin
          m   = MODE_DEC;
          off = 5'd26;
        end
        default: begin
          m   = phase[0];
          off = CFG_DATA_W'($urandom_range(0, 31));
        end
      endcase
      drain_results();
      program_regs(m, off);
      if (phase % 3 == 0) begin
        load_all_rotors();
      end
      for (int n = 0; n < 100; n++) begin
        // Once in the run the sender holds off until the output is empty.
        if (phase == 5 && n == 70) begin
          drain_results();
        end
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          it = make_load($urandom_range(0, 2), $urandom_range(0, 25), $urandom_range(0, 25));
        end else if (roll < 9) begin
          it = make_load($urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 31));
        end else begin
          if (msg_left == 0) begin
            msg_left = $urandom_range(1, 60);
            first    = 1'b1;
          end else begin
            first = ($urandom_range(0, 39) == 0);
          end
          msg_left--;
          if ($urandom_range(0, 4) != 0) begin
            ch = CHAR_W'(int'(CHAR_A) + $urandom_range(0, 25));
          end else begin
            ch = CHAR_W'($urandom_range(0, 255));
          end
          it = make_char(ch, first);
        end
        send_item(it);
      end
    end
  endtask

  // Receiver: each style holds for a random stretch, from never stalling
  // to stalling most cycles, plus a regular on/off pattern.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
      rx_left  <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_STREAM:   out_ready <= 1'b1;
      RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready <= rx_left[2];
      default:     out_ready <= 1'b1;
    endcase
  end

  // Checker: every result item is matched against the oldest prediction.
  // It also counts cycles without any handshake for the watchdog.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_cipher.size() == 0) begin
          $error("result item with nothing expected: char_out %0h", out_data.char_out);
          fail_count++;
        end else begin
          want = expected_cipher.pop_front();
          if (out_data.char_out !== want.char_out) begin
            $error("char_out expected %0h actual %0h", want.char_out, out_data.char_out);
            fail_count++;
          end
          if (out_data.passed_through !== want.passed_through) begin
            $error("passed_through expected %0b actual %0b", want.passed_through,
                   out_data.passed_through);
            fail_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog: a stuck handshake anywhere ends the run as a failure.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("rotor_shift_substitution_cipher_top regression: fail");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    load_all_rotors();
    test_encode_reset_config();
    test_bad_loads();
    test_offsets_and_decode();
    test_non_permutation();
    test_random_traffic();
    // Everything is in; let the last results and loads come out, and give
    // a stray extra result item the chance to show up.
    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_cipher.size() == 0) begin
      $display("rotor_shift_substitution_cipher_top regression: pass");
    end else begin
      $display("rotor_shift_substitution_cipher_top regression: fail");
    end
    $finish;
  end

endmodule
